// File: hdl/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types, constants and the CRC update for the frame receiver.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam int PAGE_BYTES_DEF = 64;
    localparam int BYTE_IDX_W     = 6;
    localparam int CFG_AW         = 5;
    localparam int CFG_DW         = 32;

    localparam logic [7:0]  START_BYTE = 8'hFF;
    localparam logic [7:0]  FILL_BYTE  = 8'hFF;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_TYPE_START = 3'd0;
    localparam logic [2:0] REG_TYPE_END   = 3'd1;
    localparam logic [2:0] REG_TYPE_PNUM  = 3'd2;
    localparam logic [2:0] REG_TYPE_PDATA = 3'd3;
    localparam logic [2:0] REG_VER_CHECK  = 3'd4;
    localparam logic [2:0] REG_VER_MAJOR  = 3'd5;
    localparam logic [2:0] REG_VER_MINOR  = 3'd6;

    typedef enum logic [2:0] {
        EV_FRAME   = 3'd0,
        EV_CRC     = 3'd1,
        EV_REJECT  = 3'd2,
        EV_HANDLED = 3'd3,
        EV_DONE    = 3'd4,
        EV_PAGE    = 3'd5
    } event_t;

    typedef struct packed {
        logic [7:0] type_prog_start;
        logic [7:0] type_prog_end;
        logic [7:0] type_page_number;
        logic [7:0] type_page_data;
        logic       version_check_on;
        logic [7:0] major_rev;
        logic [7:0] minor_rev;
    } cfg_t;

    // One byte of the reflected 0xA001 CRC16
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// File: hdl/bfr_if.sv
// ----------------------------------------------------------------------------
// bfr_if
// Valid/ready channels: received bytes in, receiver events out.
// ----------------------------------------------------------------------------
interface bfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic [7:0] expected_page;

    modport source (output valid, rx_byte, expected_page, input ready);
    modport sink   (input valid, rx_byte, expected_page, output ready);
endinterface

interface bfr_out_if import bfr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            event_res;
    logic                  signal_on;
    logic [7:0]            page_byte;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic                  last;

    modport source (output valid, event_res, signal_on, page_byte, byte_index, last,
                    input ready);
    modport sink   (input valid, event_res, signal_on, page_byte, byte_index, last,
                    output ready);
endinterface

// File: hdl/bfr_cfg.sv
// ----------------------------------------------------------------------------
// bfr_cfg
// APB register file: message type codes and version check settings.
// ----------------------------------------------------------------------------
module bfr_cfg
    import bfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.type_prog_start  <= 8'd1;
            cfg_reg.type_prog_end    <= 8'd2;
            cfg_reg.type_page_number <= 8'd3;
            cfg_reg.type_page_data   <= 8'd4;
            cfg_reg.version_check_on <= 1'b0;
            cfg_reg.major_rev        <= 8'd0;
            cfg_reg.minor_rev        <= 8'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TYPE_START: cfg_reg.type_prog_start  <= pwdata[7:0];
                REG_TYPE_END:   cfg_reg.type_prog_end    <= pwdata[7:0];
                REG_TYPE_PNUM:  cfg_reg.type_page_number <= pwdata[7:0];
                REG_TYPE_PDATA: cfg_reg.type_page_data   <= pwdata[7:0];
                REG_VER_CHECK:  cfg_reg.version_check_on <= pwdata[0];
                REG_VER_MAJOR:  cfg_reg.major_rev        <= pwdata[7:0];
                REG_VER_MINOR:  cfg_reg.minor_rev        <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TYPE_START: prdata = {24'd0, cfg_reg.type_prog_start};
            REG_TYPE_END:   prdata = {24'd0, cfg_reg.type_prog_end};
            REG_TYPE_PNUM:  prdata = {24'd0, cfg_reg.type_page_number};
            REG_TYPE_PDATA: prdata = {24'd0, cfg_reg.type_page_data};
            REG_VER_CHECK:  prdata = {31'd0, cfg_reg.version_check_on};
            REG_VER_MAJOR:  prdata = {24'd0, cfg_reg.major_rev};
            REG_VER_MINOR:  prdata = {24'd0, cfg_reg.minor_rev};
            default:        prdata = '0;
        endcase
    end

endmodule

// File: hdl/bfr_page_mem.sv
// ----------------------------------------------------------------------------
// bfr_page_mem
// Page buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfr_page_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/bfr_seq.sv
// ----------------------------------------------------------------------------
// bfr_seq
// Frame sequencer: byte-level frame parsing, CRC check, message actions and
// page emission out of the page buffer.
// ----------------------------------------------------------------------------
module bfr_seq
    import bfr_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    bfr_in_if.sink    in_ch,
    bfr_out_if.source out_ch
);

    localparam int AW = $clog2(PAGE_BYTES);
    localparam logic [AW-1:0] LAST_IDX  = AW'(PAGE_BYTES - 1);
    localparam logic [7:0]    PAGE_SIZE = 8'(PAGE_BYTES);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RD, S_OUT} st_t;

    typedef enum logic [3:0] {
        PH_SOM1  = 4'd0,
        PH_SOM2  = 4'd1,
        PH_FLAGS = 4'd2,
        PH_ADDR  = 4'd3,
        PH_TYPE  = 4'd4,
        PH_SECT  = 4'd5,
        PH_LEN   = 4'd6,
        PH_DATA  = 4'd7,
        PH_CRCH  = 4'd8,
        PH_CRCL  = 4'd9
    } phase_t;

    st_t     st_reg;
    phase_t  phase_reg, phase_next;
    logic    ready_reg, ready_next;
    logic    sig_reg, sig_next;
    logic [7:0]  mtype_reg, mtype_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  upc_reg, upc_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crch_reg, crch_next;
    logic [7:0]  b0_reg, b1_reg;
    logic [7:0]  rx_reg, exp_reg;
    logic [AW-1:0] idx_reg;

    logic          ov_reg;
    event_t        ev_reg;
    logic          osig_reg;
    logic [7:0]    opb_reg;
    logic [BYTE_IDX_W-1:0] oidx_reg;
    logic          olast_reg;

    logic [15:0] crc_upd;
    logic        err;
    event_t      err_ev;
    logic        res;
    event_t      res_ev;
    logic        emit;
    logic        dwr;
    logic        slot_free;
    logic        commit;
    logic        fill;
    logic        oload;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [7:0]    mem_rdata;

    assign in_ch.ready       = (st_reg == S_IDLE);
    assign out_ch.valid      = ov_reg;
    assign out_ch.event_res  = ev_reg;
    assign out_ch.signal_on  = osig_reg;
    assign out_ch.page_byte  = opb_reg;
    assign out_ch.byte_index = oidx_reg;
    assign out_ch.last       = olast_reg;

    assign slot_free = !ov_reg || out_ch.ready;
    assign crc_upd   = crc_step(crc_reg, rx_reg);
    assign commit    = (st_reg == S_EXEC) && (!res || slot_free);
    assign fill      = (8'(idx_reg) >= len_reg);
    // Load the output word: a single result, or the next page byte
    assign oload     = (commit && res) || (st_reg == S_OUT && slot_free);

    // Per-byte frame step
    always_comb
    begin
        phase_next = phase_reg;
        ready_next = ready_reg;
        sig_next   = sig_reg;
        mtype_next = mtype_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        upc_next   = upc_reg;
        crc_next   = crc_reg;
        crch_next  = crch_reg;
        err        = 1'b0;
        err_ev     = EV_FRAME;
        res        = 1'b0;
        res_ev     = EV_HANDLED;
        emit       = 1'b0;
        dwr        = 1'b0;
        unique case (phase_reg)
            PH_SOM2:
            begin
                if (rx_reg != START_BYTE)
                begin
                    err = 1'b1;
                end
                else
                begin
                    crc_next   = CRC_INIT;
                    len_next   = 8'd0;
                    phase_next = PH_FLAGS;
                end
            end
            PH_FLAGS:
            begin
                crc_next   = crc_upd;
                phase_next = PH_ADDR;
            end
            PH_ADDR:
            begin
                crc_next   = crc_upd;
                phase_next = PH_TYPE;
            end
            PH_TYPE:
            begin
                crc_next   = crc_upd;
                mtype_next = rx_reg;
                phase_next = PH_SECT;
            end
            PH_SECT:
            begin
                crc_next   = crc_upd;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                crc_next   = crc_upd;
                len_next   = rx_reg;
                cnt_next   = 8'd0;
                phase_next = (rx_reg == 8'd0) ? PH_CRCH : PH_DATA;
            end
            PH_DATA:
            begin
                crc_next = crc_upd;
                dwr      = (cnt_reg < PAGE_SIZE);
                cnt_next = cnt_reg + 8'd1;
                if (cnt_next >= len_reg)
                begin
                    phase_next = PH_CRCH;
                end
            end
            PH_CRCH:
            begin
                crch_next  = rx_reg;
                phase_next = PH_CRCL;
            end
            PH_CRCL:
            begin
                phase_next = PH_SOM1;
                if ({crch_reg, rx_reg} != crc_reg)
                begin
                    err    = 1'b1;
                    err_ev = EV_CRC;
                end
                else if (mtype_reg == cfg.type_prog_start)
                begin
                    sig_next = 1'b0;
                    if (!cfg.version_check_on ||
                        (b0_reg == cfg.major_rev && b1_reg == cfg.minor_rev))
                    begin
                        ready_next = 1'b1;
                    end
                    res = 1'b1;
                end
                else if (mtype_reg == cfg.type_prog_end)
                begin
                    ready_next = 1'b0;
                    res        = 1'b1;
                    res_ev     = EV_DONE;
                end
                else if (ready_reg && mtype_reg == cfg.type_page_number)
                begin
                    upc_next = b0_reg;
                    res      = 1'b1;
                end
                else if (ready_reg && mtype_reg == cfg.type_page_data)
                begin
                    if (len_reg > PAGE_SIZE || upc_reg != exp_reg)
                    begin
                        err    = 1'b1;
                        err_ev = EV_REJECT;
                    end
                    else
                    begin
                        sig_next = 1'b0;
                        emit     = 1'b1;
                    end
                end
                else
                begin
                    res = 1'b1;
                end
            end
            default:
            begin
                // First start byte; unused phase codes land here too
                if (rx_reg != START_BYTE)
                begin
                    err = 1'b1;
                end
                else
                begin
                    phase_next = PH_SOM2;
                end
            end
        endcase
        if (err)
        begin
            if (ready_reg)
            begin
                sig_next = 1'b1;
                upc_next = 8'd0;
            end
            phase_next = PH_SOM1;
            res        = 1'b1;
            res_ev     = err_ev;
        end
    end

    // Page buffer port: data bytes during the frame, padding during emission
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = rx_reg;
        if (commit && dwr)
        begin
            mem_we = 1'b1;
        end
        else if (st_reg == S_OUT && slot_free && fill)
        begin
            mem_we    = 1'b1;
            mem_waddr = idx_reg;
            mem_wdata = FILL_BYTE;
        end
    end

    assign mem_re = (st_reg == S_RD);

    bfr_page_mem #(
        .DEPTH (PAGE_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    // Copies of entries 0 and 1 for the version check and page number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= 8'd0;
            b1_reg <= 8'd0;
        end
        else if (mem_we)
        begin
            if (mem_waddr == AW'(0))
            begin
                b0_reg <= mem_wdata;
            end
            if (mem_waddr == AW'(1))
            begin
                b1_reg <= mem_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            rx_reg  <= in_ch.rx_byte;
            exp_reg <= in_ch.expected_page;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            phase_reg <= PH_SOM1;
            ready_reg <= 1'b0;
            sig_reg   <= 1'b0;
            mtype_reg <= 8'd0;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            upc_reg   <= 8'd0;
            crc_reg   <= CRC_INIT;
            crch_reg  <= 8'd0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
            ev_reg    <= EV_FRAME;
            osig_reg  <= 1'b0;
            opb_reg   <= 8'd0;
            oidx_reg  <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            if (oload)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        st_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (commit)
                    begin
                        phase_reg <= phase_next;
                        ready_reg <= ready_next;
                        sig_reg   <= sig_next;
                        mtype_reg <= mtype_next;
                        len_reg   <= len_next;
                        cnt_reg   <= cnt_next;
                        upc_reg   <= upc_next;
                        crc_reg   <= crc_next;
                        crch_reg  <= crch_next;
                        if (res)
                        begin
                            ev_reg    <= res_ev;
                            osig_reg  <= sig_next;
                            opb_reg   <= 8'd0;
                            oidx_reg  <= '0;
                            olast_reg <= 1'b1;
                        end
                        if (emit)
                        begin
                            idx_reg <= '0;
                            st_reg  <= S_RD;
                        end
                        else
                        begin
                            st_reg <= S_IDLE;
                        end
                    end
                end
                S_RD:
                begin
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (slot_free)
                    begin
                        ev_reg    <= EV_PAGE;
                        osig_reg  <= sig_reg;
                        opb_reg   <= fill ? FILL_BYTE : mem_rdata;
                        oidx_reg  <= BYTE_IDX_W'(idx_reg);
                        olast_reg <= (idx_reg == LAST_IDX);
                        if (idx_reg == LAST_IDX)
                        begin
                            st_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + AW'(1);
                            st_reg  <= S_RD;
                        end
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_page_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ev_reg == EV_PAGE && olast_reg) |-> (oidx_reg == BYTE_IDX_W'(LAST_IDX)))
        else $error("last page byte at wrong index");

    a_single_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ev_reg != EV_PAGE) |-> (olast_reg && opb_reg == 8'd0 && oidx_reg == '0))
        else $error("non-page result with page fields set");

    a_signal_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sig_reg) |-> $past(ready_reg))
        else $error("signal line raised while not ready for pages");

    a_emit_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_RD || st_reg == S_OUT) |-> (ready_reg && !sig_reg))
        else $error("page emission without readiness");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_EXEC && !commit) |=> (st_reg == S_EXEC && $stable(rx_reg)))
        else $error("stalled byte lost");
`endif

endmodule

// File: hdl/bootloader_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// bootloader_frame_receiver_top
// Bootloader frame receiver: frame parsing, CRC16 check and page delivery.
// ----------------------------------------------------------------------------
// Each received byte is accepted into the input register in S_IDLE; S_EXEC
// then advances the frame phase, updates the CRC16 and, during the data
// section, writes the byte into the page buffer. A byte that ends a frame
// with a single result (error, handled or done) holds in S_EXEC until the
// output register is free. An accepted page-data message is then streamed
// as PAGE_BYTES page-byte words through the registered read of the page
// buffer: S_RD reads an entry, then S_OUT, once the output register is
// free, loads the output word and writes padding 0xFF back for entries past
// the message length. No input byte is taken while a page is streaming.
// The page buffer needs no clearing pass after reset: bytes 0 and 1, the
// only entries read before being written, are mirrored in reset flip-flops.
// Configuration is an APB register file, register i at byte address 4*i.
// ----------------------------------------------------------------------------
module bootloader_frame_receiver_top
    import bfr_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    bfr_in_if.sink            in_ch,
    bfr_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;

    // Register file; writes take effect at once
    bfr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Frame sequencer with the page buffer inside
    bfr_seq #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

// File: test/bootloader_frame_receiver_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bootloader_frame_receiver_top_tb
// Self-checking bench for the bootloader frame receiver. A short table of
// frames with hand-typed outcomes comes first. Random traffic follows: mostly
// well-formed frames (start, end, page number, page data) with some noise,
// cut-off frames and corrupted CRCs. It runs under several register settings.
// A byte-level predictor in this file follows every accepted byte and
// queues the event words it must cause. Each event word the block hands out
// is checked field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module bootloader_frame_receiver_top_tb;
    import bfr_pkg::*;

    localparam int PAGE_BYTES    = 64;
    localparam int LIMIT_CYCLES  = 2000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_BYTES  = 480;
    localparam int PHASE_BYTES   = 90;

    // Receiver stall patterns
    localparam int STALL_NONE    = 0;
    localparam int STALL_RANDOM  = 1;
    localparam int STALL_PATTERN = 2;

    // Where the predictor stands within a frame
    typedef enum logic [3:0] {
        SEEK_SYNC1 = 4'd0,
        SEEK_SYNC2 = 4'd1,
        HDR_FLAGS  = 4'd2,
        HDR_ADDR   = 4'd3,
        HDR_TYPE   = 4'd4,
        HDR_SECT   = 4'd5,
        HDR_LEN    = 4'd6,
        BODY       = 4'd7,
        CRC_MSB    = 4'd8,
        CRC_LSB    = 4'd9
    } frame_phase_t;

    typedef struct packed {
        event_t     ev;
        logic       sig;
        logic [7:0] pb;
        logic [5:0] idx;
        logic       last;
    } rx_event_t;

    // One received byte to send; chk marks rows whose outcome is typed in
    typedef struct {
        logic [7:0] b;
        logic [7:0] ep;
        bit         chk;
        event_t     ev;
        logic       sig;
    } rx_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_AW-1:0]     paddr;
    logic [CFG_DW-1:0]     pwdata;
    logic [CFG_DW-1:0]     prdata;
    logic                  pready;

    bfr_in_if  in_ch ();
    bfr_out_if out_ch ();

    bootloader_frame_receiver_top #(
        .PAGE_BYTES (PAGE_BYTES)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the registers and of the frame state
    // ------------------------------------------------------------------------
    cfg_t         cfg_shadow;
    frame_phase_t frm_phase;
    logic         pages_open;
    logic         line_level;
    logic [7:0]   msg_type;
    logic [7:0]   msg_len;
    logic [7:0]   body_cnt;
    logic [7:0]   page_no;
    logic [15:0]  crc_acc;
    logic [7:0]   crc_msb;
    logic [7:0]   page_buf [PAGE_BYTES];

    rx_event_t    pending_events [$];
    rx_row_t      rx_plan [$];
    logic [7:0]   body_bytes [$];

    int           err_count;
    int           bytes_accepted;
    int           cycle_count;
    int           burst_left;
    bit           dense_send;
    int           stall_mode;
    bit           hold_req;

    // Outcome typed into the table for the byte being offered
    bit           row_chk;
    event_t       row_ev;
    logic         row_sig;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [15:0] crc16_next(logic [15:0] acc, logic [7:0] d);
        logic [15:0] r;
        r = acc ^ {8'h00, d};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void clear_predictor();
        cfg_shadow.type_prog_start  = 8'd1;
        cfg_shadow.type_prog_end    = 8'd2;
        cfg_shadow.type_page_number = 8'd3;
        cfg_shadow.type_page_data   = 8'd4;
        cfg_shadow.version_check_on = 1'b0;
        cfg_shadow.major_rev        = 8'd0;
        cfg_shadow.minor_rev        = 8'd0;
        frm_phase  = SEEK_SYNC1;
        pages_open = 1'b0;
        line_level = 1'b0;
        msg_type   = 8'd0;
        msg_len    = 8'd0;
        body_cnt   = 8'd0;
        page_no    = 8'd0;
        crc_acc    = 16'hFFFF;
        crc_msb    = 8'd0;
        for (int i = 0; i < PAGE_BYTES; i++)
        begin
            page_buf[i] = 8'd0;
        end
    endfunction

    function automatic void expect_event(event_t ev, logic [7:0] pb, logic [5:0] idx,
                                         logic last);
        rx_event_t e;
        e.ev   = ev;
        e.sig  = line_level;
        e.pb   = pb;
        e.idx  = idx;
        e.last = last;
        pending_events.push_back(e);
    endfunction

    // Errors drive the signal line and drop the page number only while
    // programming is open
    function automatic void report_fault(event_t ev);
        if (pages_open)
        begin
            line_level = 1'b1;
            page_no    = 8'd0;
        end
        frm_phase = SEEK_SYNC1;
        expect_event(ev, 8'h00, 6'd0, 1'b1);
    endfunction

    // Act on a frame whose CRC matched; the start code wins over the others
    function automatic void dispatch_message(logic [7:0] ep);
        if (msg_type == cfg_shadow.type_prog_start)
        begin
            line_level = 1'b0;
            if (!cfg_shadow.version_check_on ||
                (page_buf[0] == cfg_shadow.major_rev &&
                 page_buf[1] == cfg_shadow.minor_rev))
                pages_open = 1'b1;
            expect_event(EV_HANDLED, 8'h00, 6'd0, 1'b1);
        end
        else if (msg_type == cfg_shadow.type_prog_end)
        begin
            pages_open = 1'b0;
            expect_event(EV_DONE, 8'h00, 6'd0, 1'b1);
        end
        else if (pages_open && msg_type == cfg_shadow.type_page_number)
        begin
            page_no = page_buf[0];
            expect_event(EV_HANDLED, 8'h00, 6'd0, 1'b1);
        end
        else if (pages_open && msg_type == cfg_shadow.type_page_data)
        begin
            if (msg_len > PAGE_BYTES || page_no != ep)
                report_fault(EV_REJECT);
            else
            begin
                for (int i = 0; i < PAGE_BYTES; i++)
                begin
                    if (i >= msg_len)
                        page_buf[i] = FILL_BYTE;
                end
                line_level = 1'b0;
                for (int i = 0; i < PAGE_BYTES; i++)
                begin
                    expect_event(EV_PAGE, page_buf[i], 6'(i), (i == PAGE_BYTES - 1));
                end
            end
        end
        else
            expect_event(EV_HANDLED, 8'h00, 6'd0, 1'b1);
    endfunction

    // Advance the frame state by one received byte
    function automatic void advance_frame(logic [7:0] b, logic [7:0] ep);
        if (frm_phase >= HDR_FLAGS && frm_phase <= BODY)
            crc_acc = crc16_next(crc_acc, b);
        case (frm_phase)
            SEEK_SYNC2:
            begin
                if (b != START_BYTE)
                    report_fault(EV_FRAME);
                else
                begin
                    crc_acc   = 16'hFFFF;
                    msg_len   = 8'd0;
                    frm_phase = HDR_FLAGS;
                end
            end
            HDR_FLAGS: frm_phase = HDR_ADDR;
            HDR_ADDR:  frm_phase = HDR_TYPE;
            HDR_TYPE:
            begin
                msg_type  = b;
                frm_phase = HDR_SECT;
            end
            HDR_SECT:  frm_phase = HDR_LEN;
            HDR_LEN:
            begin
                msg_len   = b;
                body_cnt  = 8'd0;
                frm_phase = (b == 8'd0) ? CRC_MSB : BODY;
            end
            BODY:
            begin
                // bytes past the page size count toward the CRC only
                if (body_cnt < PAGE_BYTES)
                    page_buf[body_cnt[5:0]] = b;
                body_cnt = body_cnt + 8'd1;
                if (body_cnt >= msg_len)
                    frm_phase = CRC_MSB;
            end
            CRC_MSB:
            begin
                crc_msb   = b;
                frm_phase = CRC_LSB;
            end
            CRC_LSB:
            begin
                frm_phase = SEEK_SYNC1;
                if ({crc_msb, b} != crc_acc)
                    report_fault(EV_CRC);
                else
                    dispatch_message(ep);
            end
            default:
            begin
                if (b != START_BYTE)
                    report_fault(EV_FRAME);
                else
                    frm_phase = SEEK_SYNC2;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: check the outgoing word first, then predict from the incoming
    // byte. Both sample the values that stood before this edge.
    // ------------------------------------------------------------------------
    function automatic void check_event();
        rx_event_t want;
        if (pending_events.size() == 0)
        begin
            $error("unexpected word: event_res %0d byte_index %0d",
                   out_ch.event_res, out_ch.byte_index);
            err_count++;
        end
        else
        begin
            want = pending_events.pop_front();
            if (out_ch.event_res !== want.ev)
            begin
                $error("event_res: expected %0d, got %0d", want.ev, out_ch.event_res);
                err_count++;
            end
            if (out_ch.signal_on !== want.sig)
            begin
                $error("signal_on: expected %0d, got %0d", want.sig, out_ch.signal_on);
                err_count++;
            end
            if (out_ch.page_byte !== want.pb)
            begin
                $error("page_byte: expected %0h, got %0h", want.pb, out_ch.page_byte);
                err_count++;
            end
            if (out_ch.byte_index !== want.idx)
            begin
                $error("byte_index: expected %0d, got %0d", want.idx, out_ch.byte_index);
                err_count++;
            end
            if (out_ch.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, out_ch.last);
                err_count++;
            end
        end
    endfunction

    function automatic void accept_byte();
        int queued_n;
        rx_event_t typed;
        queued_n = pending_events.size();
        advance_frame(in_ch.rx_byte, in_ch.expected_page);
        // Replace the predicted word by the outcome typed into the table
        if (row_chk)
        begin
            while (pending_events.size() > queued_n)
            begin
                pending_events.delete(pending_events.size() - 1);
            end
            typed.ev   = row_ev;
            typed.sig  = row_sig;
            typed.pb   = 8'h00;
            typed.idx  = 6'd0;
            typed.last = 1'b1;
            pending_events.push_back(typed);
        end
        bytes_accepted++;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                check_event();
            if (in_ch.valid && in_ch.ready)
                accept_byte();
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on the current pattern; on request hold off for a long
    // stretch so the block backs up and stops taking bytes
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int tick;
        hold_left    = 0;
        tick         = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                hold_req  = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    STALL_RANDOM:  out_ch.ready <= ($urandom_range(0, 99) >= 35);
                    STALL_PATTERN: out_ch.ready <= ((tick % 9) < 5);
                    default:       out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: offer bytes in bursts with gaps between them. Entered and left
    // at a falling edge; valid stays up across a burst.
    // ------------------------------------------------------------------------
    task automatic send_row(rx_row_t r);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = dense_send ? 1000000 : $urandom_range(1, 24);
        end
        in_ch.valid         <= 1'b1;
        in_ch.rx_byte       <= r.b;
        in_ch.expected_page <= r.ep;
        row_chk             <= r.chk;
        row_ev              <= r.ev;
        row_sig             <= r.sig;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        burst_left--;
        if (burst_left == 0)
            in_ch.valid <= 1'b0;
    endtask

    task automatic send_plan();
        while (rx_plan.size() != 0)
        begin
            send_row(rx_plan.pop_front());
        end
    endtask

    // Drop valid at the end of a stretch of traffic
    task automatic stop_sender();
        if (burst_left != 0)
        begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------
    function automatic void store_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            REG_TYPE_START: cfg_shadow.type_prog_start  = data[7:0];
            REG_TYPE_END:   cfg_shadow.type_prog_end    = data[7:0];
            REG_TYPE_PNUM:  cfg_shadow.type_page_number = data[7:0];
            REG_TYPE_PDATA: cfg_shadow.type_page_data   = data[7:0];
            REG_VER_CHECK:  cfg_shadow.version_check_on = data[0];
            REG_VER_MAJOR:  cfg_shadow.major_rev        = data[7:0];
            REG_VER_MINOR:  cfg_shadow.minor_rev        = data[7:0];
            default: ;
        endcase
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        store_reg(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write every register; upper data bits carry junk that must be ignored
    task automatic set_config(cfg_t c);
        logic [31:0] junk;
        junk = $urandom();
        cfg_write(REG_TYPE_START, {junk[31:8], c.type_prog_start});
        cfg_write(REG_TYPE_END,   {junk[31:8], c.type_prog_end});
        cfg_write(REG_TYPE_PNUM,  {junk[31:8], c.type_page_number});
        cfg_write(REG_TYPE_PDATA, {junk[31:8], c.type_page_data});
        cfg_write(REG_VER_CHECK,  {junk[31:1], c.version_check_on});
        cfg_write(REG_VER_MAJOR,  {junk[31:8], c.major_rev});
        cfg_write(REG_VER_MINOR,  {junk[31:8], c.minor_rev});
    endtask

    // Let every queued word drain, then give trailing mid-frame bytes time
    task automatic wait_drained();
        while (pending_events.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Frame building
    // ------------------------------------------------------------------------
    function automatic void push_row(logic [7:0] b);
        rx_row_t r;
        r.b   = b;
        r.ep  = 8'($urandom_range(0, 255));
        r.chk = 1'b0;
        r.ev  = EV_FRAME;
        r.sig = 1'b0;
        rx_plan.push_back(r);
    endfunction

    function automatic void mark_last(event_t ev, logic sig);
        rx_plan[rx_plan.size() - 1].chk = 1'b1;
        rx_plan[rx_plan.size() - 1].ev  = ev;
        rx_plan[rx_plan.size() - 1].sig = sig;
    endfunction

    // Append a whole frame around body_bytes; the page number expected by
    // the loader only counts on the last CRC byte
    function automatic void append_frame(logic [7:0] typ, bit bad_crc, logic [7:0] last_ep);
        logic [7:0]  hdr [5];
        logic [15:0] crc;
        hdr[0] = 8'($urandom_range(0, 255));
        hdr[1] = 8'($urandom_range(0, 255));
        hdr[2] = typ;
        hdr[3] = 8'($urandom_range(0, 255));
        hdr[4] = 8'(body_bytes.size());
        crc    = 16'hFFFF;
        push_row(START_BYTE);
        push_row(START_BYTE);
        for (int i = 0; i < 5; i++)
        begin
            push_row(hdr[i]);
            crc = crc16_next(crc, hdr[i]);
        end
        foreach (body_bytes[i])
        begin
            push_row(body_bytes[i]);
            crc = crc16_next(crc, body_bytes[i]);
        end
        if (bad_crc)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        push_row(crc[15:8]);
        push_row(crc[7:0]);
        rx_plan[rx_plan.size() - 1].ep = last_ep;
    endfunction

    function automatic void fill_body(int len);
        body_bytes.delete();
        repeat (len) body_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Plan one unit of random traffic: mostly well-formed frames, some noise
    // and some frames cut short or with a broken CRC
    function automatic void plan_random_unit();
        int         r;
        int         k;
        int         s;
        logic [7:0] typ;
        logic [7:0] ep;
        r  = $urandom_range(0, 99);
        k  = $urandom_range(0, 99);
        ep = 8'($urandom_range(0, 255));
        if (r < 5)
        begin
            repeat ($urandom_range(1, 3))
            begin
                push_row(($urandom_range(0, 2) == 0) ? START_BYTE :
                         8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            if ((!pages_open && k < 70) || k < 10)
            begin
                typ = cfg_shadow.type_prog_start;
                fill_body($urandom_range(0, 3));
                if (cfg_shadow.version_check_on && body_bytes.size() >= 2 &&
                    $urandom_range(0, 3) != 0)
                begin
                    body_bytes[0] = cfg_shadow.major_rev;
                    body_bytes[1] = cfg_shadow.minor_rev;
                end
            end
            else if (k < 18)
            begin
                typ = cfg_shadow.type_prog_end;
                fill_body($urandom_range(0, 2));
            end
            else if (k < 40)
            begin
                typ = cfg_shadow.type_page_number;
                fill_body($urandom_range(1, 2));
                if ($urandom_range(0, 1) == 0)
                    body_bytes[0] = 8'($urandom_range(0, 3));
            end
            else if (k < 90)
            begin
                typ = cfg_shadow.type_page_data;
                s   = $urandom_range(0, 99);
                // mostly short pages; full pages and over-long bodies now and then
                if (s < 55)
                    fill_body($urandom_range(0, 8));
                else if (s < 85)
                    fill_body($urandom_range(9, PAGE_BYTES - 1));
                else if (s < 95)
                    fill_body(PAGE_BYTES);
                else
                    fill_body($urandom_range(PAGE_BYTES + 1, 255));
                if ($urandom_range(0, 99) < 85)
                    ep = page_no;
            end
            else
            begin
                typ = 8'($urandom_range(0, 255));
                fill_body($urandom_range(0, 4));
            end
            append_frame(typ, ($urandom_range(0, 99) < 6), ep);
            // cut the frame short; the next sync bytes then land mid-frame
            if (r < 10)
            begin
                repeat ($urandom_range(1, 4)) rx_plan.delete(rx_plan.size() - 1);
            end
        end
    endfunction

    task automatic run_traffic(int quota);
        int first;
        first = bytes_accepted;
        while (bytes_accepted - first < quota)
        begin
            plan_random_unit();
            send_plan();
        end
        stop_sender();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cfg_t c;
        int   rnd_first;
        int   p;

        // Hold every input at a known value from time zero
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_ch.valid         = 1'b0;
        in_ch.rx_byte       = 8'h00;
        in_ch.expected_page = 8'h00;
        row_chk             = 1'b0;
        row_ev              = EV_FRAME;
        row_sig             = 1'b0;
        err_count           = 0;
        bytes_accepted      = 0;
        burst_left          = 0;
        dense_send          = 1'b0;
        stall_mode          = STALL_PATTERN;
        hold_req            = 1'b0;
        clear_predictor();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table under reset settings: bad first sync byte, bad
        // second sync byte, page data before programming opens, then an
        // empty start message that opens programming
        push_row(8'h00);
        mark_last(EV_FRAME, 1'b0);
        push_row(START_BYTE);
        push_row(8'h7E);
        mark_last(EV_FRAME, 1'b0);
        body_bytes.delete();
        append_frame(cfg_shadow.type_page_data, 1'b0, 8'hFF);
        mark_last(EV_HANDLED, 1'b0);
        append_frame(cfg_shadow.type_prog_start, 1'b0, 8'h00);
        mark_last(EV_HANDLED, 1'b0);
        send_plan();
        stop_sender();

        // Random traffic, one register setting per stretch
        rnd_first = bytes_accepted;
        p = 1;
        while (p <= 4 || bytes_accepted - rnd_first < RANDOM_BYTES)
        begin
            wait_drained();
            stall_mode = p % 3;
            dense_send = (p % 4 == 0);
            case (p)
                1:
                begin
                    // reset values written back explicitly
                    c.type_prog_start  = 8'd1;
                    c.type_prog_end    = 8'd2;
                    c.type_page_number = 8'd3;
                    c.type_page_data   = 8'd4;
                    c.version_check_on = 1'b0;
                    c.major_rev        = 8'h00;
                    c.minor_rev        = 8'h00;
                end
                2:
                begin
                    // extreme codes and versions, version check on
                    c.type_prog_start  = 8'h00;
                    c.type_prog_end    = 8'hFF;
                    c.type_page_number = 8'h80;
                    c.type_page_data   = 8'h7F;
                    c.version_check_on = 1'b1;
                    c.major_rev        = 8'hFF;
                    c.minor_rev        = 8'h00;
                end
                3:
                begin
                    // equal codes: start beats end, page number beats data
                    c.type_prog_start  = 8'h20;
                    c.type_prog_end    = 8'h20;
                    c.type_page_number = 8'h31;
                    c.type_page_data   = 8'h31;
                    c.version_check_on = 1'b1;
                    c.major_rev        = 8'h5A;
                    c.minor_rev        = 8'hA5;
                end
                default:
                begin
                    c.type_prog_start  = 8'($urandom_range(0, 255));
                    c.type_prog_end    = 8'($urandom_range(0, 255));
                    c.type_page_number = 8'($urandom_range(0, 255));
                    c.type_page_data   = 8'($urandom_range(0, 255));
                    c.version_check_on = 1'($urandom_range(0, 1));
                    c.major_rev        = 8'($urandom_range(0, 255));
                    c.minor_rev        = 8'($urandom_range(0, 255));
                end
            endcase
            set_config(c);
            // back up the block once while pages are flowing
            if (p == 1)
                hold_req = 1'b1;
            run_traffic((p == 3) ? 60 : PHASE_BYTES);
            p++;
        end

        // Drain, let the tail settle, then report
        while (pending_events.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: bootloader_frame_receiver_top.f
hdl/bfr_pkg.sv
hdl/bfr_if.sv
hdl/bfr_cfg.sv
hdl/bfr_page_mem.sv
hdl/bfr_seq.sv
hdl/bootloader_frame_receiver_top.sv
test/bootloader_frame_receiver_top_tb.sv
